### rtl/core/rfe_pkg.sv
// ----------------------------------------------------------------------------
// rfe_pkg: shared types and constants for the relocation fixup evaluator
// Request, operand source, operator and patch kind codes, field widths.
// ----------------------------------------------------------------------------
package rfe_pkg;

  localparam int unsigned SYMBOL_DEPTH_DEF = 4096;
  localparam int unsigned VALUE_WIDTH_DEF  = 32;
  localparam logic [15:0] CODE_BASE_RST    = 16'h8000;

  typedef enum logic [2:0] {
    REQ_LOAD_EXP = 3'd0,
    REQ_LOAD_INT = 3'd1,
    REQ_LOAD_MAP = 3'd2,
    REQ_BEGIN    = 3'd3,
    REQ_OPERAND  = 3'd4,
    REQ_OPERATOR = 3'd5,
    REQ_END      = 3'd6,
    REQ_NONE     = 3'd7
  } req_t;

  localparam logic [1:0] SRC_IMPORT   = 2'd0;
  localparam logic [1:0] SRC_INTERNAL = 2'd1;
  localparam logic [1:0] SRC_LITERAL  = 2'd2;

  localparam logic [3:0] OP_ADD = 4'd0;
  localparam logic [3:0] OP_SUB = 4'd1;
  localparam logic [3:0] OP_OR  = 4'd2;
  localparam logic [3:0] OP_XOR = 4'd3;
  localparam logic [3:0] OP_MUL = 4'd4;
  localparam logic [3:0] OP_AND = 4'd5;
  localparam logic [3:0] OP_SHL = 4'd6;
  localparam logic [3:0] OP_SAR = 4'd7;
  localparam logic [3:0] OP_DIV = 4'd8;
  localparam logic [3:0] OP_NEG = 4'd9;
  localparam logic [3:0] OP_NOT = 4'd10;

  localparam logic [2:0] KIND_BYTE = 3'd0;
  localparam logic [2:0] KIND_OR3S = 3'd1;
  localparam logic [2:0] KIND_OR3U = 3'd2;
  localparam logic [2:0] KIND_HALF = 3'd3;
  localparam logic [2:0] KIND_WORD = 3'd4;
  localparam logic [2:0] KIND_REL  = 3'd5;

  // divider handshake
  typedef struct packed {
    logic start;
  } div_ctl_t;

endpackage

### rtl/core/rfe_divider.sv
// ----------------------------------------------------------------------------
// rfe_divider: signed truncating divider, one quotient bit per cycle
// Divide by zero gives 0; most negative / -1 wraps.
// ----------------------------------------------------------------------------
module rfe_divider #(
  parameter int unsigned VALUE_WIDTH = rfe_pkg::VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  rfe_pkg::div_ctl_t      ctl,
  input  logic [VALUE_WIDTH-1:0] dividend,
  input  logic [VALUE_WIDTH-1:0] divisor,
  output logic                   done,
  output logic [VALUE_WIDTH-1:0] quotient
);

  localparam int unsigned CW = $clog2(VALUE_WIDTH + 1);

  logic [VALUE_WIDTH-1:0] rem_r, quo_r, dvs_r;
  logic [CW-1:0]          cnt_r;
  logic                   busy_r, neg_r, done_r;
  logic [VALUE_WIDTH:0]   trial;
  logic [VALUE_WIDTH-1:0] ma, mb;

  assign ma = dividend[VALUE_WIDTH-1] ? (~dividend + 1'b1) : dividend;
  assign mb = divisor[VALUE_WIDTH-1] ? (~divisor + 1'b1) : divisor;
  assign trial = {rem_r, quo_r[VALUE_WIDTH-1]} - {1'b0, dvs_r};

  // restoring shift-subtract loop
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(VALUE_WIDTH);
        rem_r  <= '0;
        quo_r  <= ma;
        dvs_r  <= mb;
        neg_r  <= dividend[VALUE_WIDTH-1] ^ divisor[VALUE_WIDTH-1];
      end else if (busy_r) begin
        if (!trial[VALUE_WIDTH]) begin
          rem_r <= trial[VALUE_WIDTH-1:0];
          quo_r <= {quo_r[VALUE_WIDTH-2:0], 1'b1};
        end else begin
          rem_r <= {rem_r[VALUE_WIDTH-2:0], quo_r[VALUE_WIDTH-1]};
          quo_r <= {quo_r[VALUE_WIDTH-2:0], 1'b0};
        end
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  // zero divisor: all quotient bits come out 1; forced to 0 here when dvs_r is zero
  assign quotient = (dvs_r == '0) ? '0 : (neg_r ? (~quo_r + 1'b1) : quo_r);

endmodule

### rtl/core/relocation_fixup_evaluator_unit.sv
// ----------------------------------------------------------------------------
// relocation_fixup_evaluator_unit: linker relocation engine
// Table loads, postfix expression evaluation and byte-patch emission.
// ----------------------------------------------------------------------------
// Table loads, begin, literal and most operators finish on acceptance;
//   internal operands pass through S_INT, import operands through S_MAP
//   and S_EXP (chained memory reads). Divide waits in S_DIV (bit-serial).
// End items give up to two output transfers, one per cycle under out_tready.
// Reset (synchronous, rst_n low) clears evaluator registers, code_base to
//   0x8000; the symbol tables are not cleared and hold stale data.
module relocation_fixup_evaluator_unit #(
  parameter int unsigned SYMBOL_DEPTH = rfe_pkg::SYMBOL_DEPTH_DEF,
  parameter int unsigned VALUE_WIDTH  = rfe_pkg::VALUE_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  // tdata: req_type[2:0], table_index[14:3], table_value[30:15],
  //   patch_pos[46:31], patch_kind[49:47], operand_source[51:50],
  //   operand_value[67:52], operator_code[71:68]
  input  logic [71:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // tdata: write_addr[15:0], write_byte[23:16], or_merge[24], divide_fault[25]
  output logic [31:0] out_tdata,
  output logic        out_tlast
);

  localparam int unsigned AW = $clog2(SYMBOL_DEPTH);
  localparam int unsigned VW = VALUE_WIDTH;
  localparam int unsigned SW = $clog2(VW);

  typedef enum logic [2:0] {
    S_IDLE, S_MAP, S_EXP, S_INT, S_DIV, S_OUT1
  } state_t;

  // input fields
  logic [2:0]  f_req;
  logic [11:0] f_tidx;
  logic [15:0] f_tval, f_ppos, f_oval;
  logic [2:0]  f_kind;
  logic [1:0]  f_src;
  logic [3:0]  f_opc;
  assign f_req  = in_tdata[2:0];
  assign f_tidx = in_tdata[14:3];
  assign f_tval = in_tdata[30:15];
  assign f_ppos = in_tdata[46:31];
  assign f_kind = in_tdata[49:47];
  assign f_src  = in_tdata[51:50];
  assign f_oval = in_tdata[67:52];
  assign f_opc  = in_tdata[71:68];

  // symbol memories
  logic [15:0] exp_mem [SYMBOL_DEPTH];
  logic [15:0] int_mem [SYMBOL_DEPTH];
  logic [11:0] map_mem [SYMBOL_DEPTH];
  logic [15:0] exp_q, int_q;
  logic [11:0] map_q;
  logic [AW-1:0] exp_ra, int_ra, map_ra, wa;
  logic          exp_ok_r, int_ok_r, map_ok_r;

  state_t        state_r;
  logic [VW-1:0] a_r, b_r;
  logic [15:0]   pos_r, code_base_r;
  logic [2:0]    kind_r;
  logic          fault_r;
  logic [15:0]   o_addr_r;
  logic [7:0]    o_byte_r, hi_byte_r;
  logic          o_merge_r, o_last_r, o_valid_r;

  logic acc, in_range_w, in_range_o, in_range_m;
  assign in_tready = (state_r == S_IDLE) && !o_valid_r;
  assign acc = in_tvalid && in_tready;
  assign wa  = AW'(f_tidx);
  assign in_range_w = {20'd0, f_tidx} < 32'(SYMBOL_DEPTH);
  assign in_range_o = {16'd0, f_oval} < 32'(SYMBOL_DEPTH);
  assign in_range_m = {20'd0, map_q} < 32'(SYMBOL_DEPTH);
  assign map_ra = AW'(f_oval);
  assign int_ra = AW'(f_oval);
  // an import index past the map reads export entry 0
  assign exp_ra = map_ok_r ? AW'(map_q) : '0;

  // memory writes and registered reads
  always_ff @(posedge clk) begin
    if (acc && in_range_w && f_req == rfe_pkg::REQ_LOAD_EXP) exp_mem[wa] <= f_tval;
    if (acc && in_range_w && f_req == rfe_pkg::REQ_LOAD_INT) int_mem[wa] <= f_tval;
    if (acc && in_range_w && f_req == rfe_pkg::REQ_LOAD_MAP) map_mem[wa] <= f_tval[11:0];
    map_q <= map_mem[map_ra];
    int_q <= int_mem[int_ra];
    exp_q <= exp_mem[exp_ra];
  end

  // divider
  rfe_pkg::div_ctl_t div_ctl;
  logic              div_done;
  logic [VW-1:0]     div_q;
  assign div_ctl.start = acc && f_req == rfe_pkg::REQ_OPERATOR && f_opc == rfe_pkg::OP_DIV;

  rfe_divider #(.VALUE_WIDTH(VW)) u_div (
    .clk(clk), .rst_n(rst_n), .ctl(div_ctl), .dividend(a_r), .divisor(b_r),
    .done(div_done), .quotient(div_q)
  );

  // operator ALU
  logic [VW-1:0] alu, sar_v, tb, t_half, t_rel;
  logic          big_sh;
  assign big_sh = (b_r >= VW'(VW));
  assign sar_v  = big_sh ? {VW{a_r[VW-1]}} : VW'($signed(a_r) >>> b_r[SW-1:0]);
  always_comb begin
    alu = b_r;
    case (f_opc)
      rfe_pkg::OP_ADD: alu = a_r + b_r;
      rfe_pkg::OP_SUB: alu = a_r - b_r;
      rfe_pkg::OP_OR:  alu = a_r | b_r;
      rfe_pkg::OP_XOR: alu = a_r ^ b_r;
      rfe_pkg::OP_MUL: alu = VW'(a_r * b_r);
      rfe_pkg::OP_AND: alu = a_r & b_r;
      rfe_pkg::OP_SHL: alu = big_sh ? '0 : (a_r << b_r[SW-1:0]);
      rfe_pkg::OP_SAR: alu = sar_v;
      rfe_pkg::OP_NEG: alu = '0 - b_r;
      rfe_pkg::OP_NOT: alu = ~b_r;
      default:         alu = b_r;
    endcase
  end

  // end-item fixups
  assign tb     = b_r - VW'({1'b0, pos_r} + 17'd1);
  assign t_half = VW'($signed(tb + VW'(tb[VW-1])) >>> 1);
  assign t_rel  = b_r - VW'({1'b0, pos_r} + 17'd2);

  // control and evaluator state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      a_r         <= '0;
      b_r         <= '0;
      pos_r       <= '0;
      kind_r      <= '0;
      fault_r     <= 1'b0;
      code_base_r <= rfe_pkg::CODE_BASE_RST;
      o_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) code_base_r <= cfg_wdata;
      // S_OUT1 reloads the second write itself
      if (o_valid_r && out_tready && state_r != S_OUT1) o_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: if (acc) begin
          case (f_req)
            rfe_pkg::REQ_BEGIN: begin
              pos_r   <= f_ppos + code_base_r;
              kind_r  <= f_kind;
              fault_r <= 1'b0;
            end
            rfe_pkg::REQ_OPERAND: begin
              map_ok_r <= in_range_o;
              int_ok_r <= in_range_o;
              case (f_src)
                rfe_pkg::SRC_IMPORT:   state_r <= S_MAP;
                rfe_pkg::SRC_INTERNAL: state_r <= S_INT;
                rfe_pkg::SRC_LITERAL: begin
                  a_r <= b_r;
                  b_r <= VW'(f_oval);
                end
                default: ;
              endcase
            end
            rfe_pkg::REQ_OPERATOR: begin
              if (f_opc == rfe_pkg::OP_DIV) state_r <= S_DIV;
              else b_r <= alu;
            end
            rfe_pkg::REQ_END: begin
              fault_r   <= 1'b0;
              o_addr_r  <= pos_r;
              o_valid_r <= (kind_r <= rfe_pkg::KIND_REL);
              o_last_r  <= 1'b1;
              o_merge_r <= 1'b0;
              case (kind_r)
                rfe_pkg::KIND_BYTE: o_byte_r <= b_r[7:0];
                rfe_pkg::KIND_OR3S, rfe_pkg::KIND_OR3U: begin
                  o_byte_r  <= {5'd0, b_r[2:0]};
                  o_merge_r <= 1'b1;
                end
                rfe_pkg::KIND_HALF: begin
                  b_r       <= t_half;
                  o_byte_r  <= {5'd0, t_half[2:0]};
                  o_merge_r <= 1'b1;
                end
                rfe_pkg::KIND_WORD: begin
                  o_byte_r  <= b_r[7:0];
                  hi_byte_r <= b_r[15:8];
                  o_last_r  <= 1'b0;
                  state_r   <= S_OUT1;
                end
                rfe_pkg::KIND_REL: begin
                  b_r       <= t_rel;
                  o_byte_r  <= t_rel[7:0];
                  hi_byte_r <= t_rel[15:8];
                  o_last_r  <= 1'b0;
                  state_r   <= S_OUT1;
                end
                default: ;
              endcase
            end
            default: ;
          endcase
        end
        // map entry is in map_q now; export read issues this cycle
        S_MAP: begin
          exp_ok_r <= !map_ok_r || in_range_m;
          state_r  <= S_EXP;
        end
        S_EXP: begin
          a_r     <= b_r;
          b_r     <= exp_ok_r ? VW'(exp_q) : '0;
          state_r <= S_IDLE;
        end
        S_INT: begin
          a_r     <= b_r;
          b_r     <= int_ok_r ? VW'(int_q) : '0;
          state_r <= S_IDLE;
        end
        S_DIV: if (div_done) begin
          b_r <= div_q;
          if (b_r == '0) fault_r <= 1'b1;
          state_r <= S_IDLE;
        end
        S_OUT1: if (out_tready) begin
          o_valid_r <= 1'b1;
          o_addr_r  <= o_addr_r + 16'd1;
          o_byte_r  <= hi_byte_r;
          o_last_r  <= 1'b1;
          state_r   <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // fault reported is the flag before the end item cleared it
  logic o_fault_r;
  always_ff @(posedge clk) begin
    if (acc && f_req == rfe_pkg::REQ_END) o_fault_r <= fault_r;
  end

  assign out_tvalid = o_valid_r;
  assign out_tdata  = {6'd0, o_fault_r, o_merge_r, o_byte_r, o_addr_r};
  assign out_tlast  = o_last_r;

endmodule

### rtl/core/rfe_checker.sv
// ----------------------------------------------------------------------------
// rfe_checker: port-level checks for the relocation fixup evaluator
// Watches the handshake and result ordering on the top-level ports.
// ----------------------------------------------------------------------------
module rfe_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tlast
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed under stall");

  // no new item while a result waits
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("input taken while result pending");

  // second write of a pair follows at the next address
  a_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tvalid &&
      out_tdata[15:0] == $past(out_tdata[15:0]) + 16'd1)
    else $error("pair write address wrong");

endmodule

bind relocation_fixup_evaluator_unit rfe_checker u_rfe_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
  .out_tlast(out_tlast)
);
